@@ rtl/core/fbd_pkg.sv @@
// Shared types and constants for the field bob deinterlacer.
package fbd_pkg;

  localparam int unsigned ChW   = 16;
  localparam int unsigned PosW  = 12;
  localparam int unsigned CfgW  = 13;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned PixW  = 4 * ChW;

  localparam logic [CfgIdxW-1:0] REG_FIELD_ORDER  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_LINE_WIDTH   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam logic [CfgW-1:0] LINE_WIDTH_RESET   = 13'd720;
  localparam logic [CfgW-1:0] FRAME_HEIGHT_RESET = 13'd480;

  typedef struct packed {
    logic [ChW-1:0] in_ch0;
    logic [ChW-1:0] in_ch1;
    logic [ChW-1:0] in_ch2;
    logic [ChW-1:0] in_ch3;
    logic           second_field;
  } pix_in_t;

  typedef struct packed {
    logic [ChW-1:0]  out_ch0;
    logic [ChW-1:0]  out_ch1;
    logic [ChW-1:0]  out_ch2;
    logic [ChW-1:0]  out_ch3;
    logic [PosW-1:0] out_row;
    logic [PosW-1:0] out_col;
    logic            last_of_run;
  } pix_out_t;

  // Which result of a kept pixel is being sent.
  typedef enum logic [1:0] {
    KIND_PRE,   // rebuilt or repeated pixel of the missing row above
    KIND_MAIN,  // the kept pixel itself
    KIND_POST   // repeated pixel of a missing last row
  } kind_t;

  // Per-channel truncated average; ch0 sits in the low bits.
  function automatic logic [PixW-1:0] avg_px(input logic [PixW-1:0] a,
                                             input logic [PixW-1:0] b);
    logic [PixW-1:0] r;
    logic [ChW:0]    s;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      s = {1'b0, a[k*ChW +: ChW]} + {1'b0, b[k*ChW +: ChW]};
      r[k*ChW +: ChW] = s[ChW:1];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/field_bob_deinterlace_top.sv @@
// Top level of the field bob deinterlacer: raster counters, line store, result sequencer.
//
// Channel   Handshake               Payload
// -------   ---------------------   ----------------------------------------
// input     in_valid / in_ready     in_data   (pix_in_t: 4 x 16b pixel, field flag)
// output    out_valid / out_ready   out_data  (pix_out_t: 4 x 16b pixel, row, col, last)
// config    cfg_wr_en               cfg_index (2b), cfg_data (13b), no wait
//
// A pixel of a missing row is taken and sends nothing.
// A kept pixel holds the item stage for its results: two (one on row 0), one more when it
// also fills a missing last row; the output register sends one per cycle unless stalled.
// The line store read is issued on acceptance and its data held until the item leaves.
// rst is synchronous; counters, field parity, configuration and valid flags return to defaults.
// A stalled output holds its result; a new request is taken in the cycle the last
// result of the current one moves to the output register.
module field_bob_deinterlace_top
  import fbd_pkg::*;
#(
  parameter int unsigned MAX_LINE_WIDTH   = 4096,
  parameter int unsigned MAX_FRAME_HEIGHT = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  pix_in_t            in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pix_out_t           out_data
);

  localparam int unsigned ColW = $clog2(MAX_LINE_WIDTH);
  localparam int unsigned RowW = $clog2(MAX_FRAME_HEIGHT);

  // configuration
  logic            field_order;
  logic [CfgW-1:0] line_width;
  logic [CfgW-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_order  <= 1'b0;
      line_width   <= LINE_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FIELD_ORDER:  field_order  <= cfg_data[0];
        REG_LINE_WIDTH:   line_width   <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped geometry, kept at 32 bits for compares
  logic [31:0] eff_w, eff_h;

  always_comb begin
    if (line_width == '0) begin
      eff_w = 32'd1;
    end else if (32'(line_width) > MAX_LINE_WIDTH) begin
      eff_w = 32'(MAX_LINE_WIDTH);
    end else begin
      eff_w = 32'(line_width);
    end
    if (32'(frame_height) < 32'd2) begin
      eff_h = 32'd2;
    end else if (32'(frame_height) > MAX_FRAME_HEIGHT) begin
      eff_h = 32'(MAX_FRAME_HEIGHT);
    end else begin
      eff_h = 32'(frame_height);
    end
  end

  // raster position of the incoming pixel
  logic [ColW-1:0] column_count;
  logic [RowW-1:0] row_count;
  logic            kept_parity;
  logic [ColW-1:0] cur_col, column_count_next;
  logic [RowW-1:0] cur_row, row_count_next;
  logic            kept_parity_next;
  logic            cur_kept, cur_pre, cur_avg, cur_post;
  logic [31:0]     col_inc, row_inc;

  always_comb begin
    cur_col = (32'(column_count) >= eff_w) ? '0 : column_count;
    cur_row = (32'(row_count) >= eff_h) ? '0 : row_count;

    kept_parity_next = kept_parity;
    if (cur_row == '0 && cur_col == '0) begin
      kept_parity_next = in_data.second_field ^ field_order;
    end
    cur_kept = (cur_row[0] == kept_parity_next);
    cur_pre  = (cur_row != '0);
    cur_avg  = (32'(cur_row) >= 32'd2);
    cur_post = ((32'(cur_row) + 32'd2) == eff_h);

    col_inc = 32'(cur_col) + 32'd1;
    row_inc = 32'(cur_row) + 32'd1;
    column_count_next = col_inc[ColW-1:0];
    row_count_next    = cur_row;
    if (col_inc >= eff_w) begin
      column_count_next = '0;
      row_count_next    = (row_inc >= eff_h) ? '0 : row_inc[RowW-1:0];
    end
  end

  // item stage: a kept pixel waiting to send its results
  logic            a_valid;
  logic [PixW-1:0] a_px;
  logic [RowW-1:0] a_row;
  logic [ColW-1:0] a_col;
  logic            a_avg, a_post;
  kind_t           a_kind, kind_next;
  logic            a_last, load, a_done, accept;
  logic [PixW-1:0] in_px, line_rdata;

  assign in_px  = {in_data.in_ch3, in_data.in_ch2, in_data.in_ch1, in_data.in_ch0};
  assign load   = a_valid && (!out_valid || out_ready);
  assign a_done = load && a_last;
  assign in_ready = !a_valid || a_done;
  assign accept   = in_valid && in_ready;

  fbd_ram #(
    .WIDTH(PixW),
    .DEPTH(MAX_LINE_WIDTH)
  ) u_line_store (
    .clk  (clk),
    .we   (accept && cur_kept),
    .waddr(cur_col),
    .wdata(in_px),
    .re   (accept && cur_kept),
    .raddr(cur_col),
    .rdata(line_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      kept_parity  <= 1'b0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      kept_parity  <= kept_parity_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      a_kind  <= KIND_MAIN;
    end else if (accept) begin
      a_valid <= cur_kept;
      a_kind  <= cur_pre ? KIND_PRE : KIND_MAIN;
    end else if (a_done) begin
      a_valid <= 1'b0;
    end else if (load) begin
      a_kind <= kind_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_px   <= in_px;
      a_row  <= cur_row;
      a_col  <= cur_col;
      a_avg  <= cur_avg;
      a_post <= cur_post;
    end
  end

  // result sequencing: next kind
  always_comb begin
    unique case (a_kind)
      KIND_PRE:  kind_next = KIND_MAIN;
      KIND_MAIN: kind_next = KIND_POST;
      KIND_POST: kind_next = KIND_POST;
      default:   kind_next = KIND_MAIN;
    endcase
  end

  // result sequencing: result of the current kind
  pix_out_t    res;
  logic [PixW-1:0] res_px;
  logic [31:0] res_row;

  always_comb begin
    res_px  = a_px;
    res_row = 32'(a_row);
    a_last  = 1'b0;
    unique case (a_kind)
      KIND_PRE: begin
        res_px  = a_avg ? avg_px(line_rdata, a_px) : a_px;
        res_row = 32'(a_row) - 32'd1;
      end
      KIND_MAIN: begin
        a_last = !a_post;
      end
      KIND_POST: begin
        res_row = 32'(a_row) + 32'd1;
        a_last  = 1'b1;
      end
      default: ;
    endcase
    res.out_ch0     = res_px[0*ChW +: ChW];
    res.out_ch1     = res_px[1*ChW +: ChW];
    res.out_ch2     = res_px[2*ChW +: ChW];
    res.out_ch3     = res_px[3*ChW +: ChW];
    res.out_row     = res_row[PosW-1:0];
    res.out_col     = PosW'(32'(a_col));
    res.last_of_run = a_last;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res;
    end
  end

  // a missing-row pixel must never occupy the item stage
  assert property (@(posedge clk) disable iff (rst)
    accept && !cur_kept |=> !a_valid)
    else $error("missing-row pixel held in item stage");

  // a row-0 pixel has no row above to fill
  assert property (@(posedge clk) disable iff (rst)
    a_valid && a_kind == KIND_PRE |-> a_row != '0)
    else $error("upper fill result for row 0");

  // the bottom repeat is only sent for a pixel just above a missing last row
  assert property (@(posedge clk) disable iff (rst)
    a_valid && a_kind == KIND_POST |-> a_post)
    else $error("bottom repeat without missing last row");

  // a loaded result that ends the run frees the item stage unless refilled
  assert property (@(posedge clk) disable iff (rst)
    a_done && !(in_valid && cur_kept) |=> !a_valid)
    else $error("item stage not released after last result");

endmodule

@@ rtl/core/fbd_ram.sv @@
// Generic single-port-write, registered-read RAM.
module fbd_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
